### sv/bssa_pkg.sv
package bssa_pkg;

   localparam int MAX_ENTRIES_DEF = 32;

   localparam logic [31:0] IO_TYPE_MASK  = 32'h0000_0003;
   localparam logic [31:0] MEM_TYPE_MASK = 32'h0000_000F;

   localparam logic CSR_MEM_WINDOW_BASE = 1'b0;
   localparam logic CSR_IO_WINDOW_BASE  = 1'b1;

   typedef struct packed {
      logic [10:0] tag;
      logic [31:0] value;
      logic [31:0] size;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

endpackage

### sv/bar_size_sort_allocator.sv
// Each item with a nonzero probe readback unlike its original value is sorted into the
// cell chain in the cycle it is accepted, unless full; one item per cycle while collecting.
// After a final item, results leave the chain head one per cycle while rsp_ready allows;
// no item is accepted during emission. Each result adds its size to one address cursor.
// Synchronous reset empties the chain, clears the window bases and the overflow flag.
module bar_size_sort_allocator import bssa_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [10:0] req_entry_tag,
   input  logic [31:0] req_original_value,
   input  logic [31:0] req_probe_readback,
   input  logic        req_final_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_result_tag,
   output logic [31:0] rsp_assigned_value,
   output logic [31:0] rsp_region_size,
   output logic        rsp_is_io_space,
   output logic        rsp_capacity_overflow,
   output logic        rsp_last_result
);

   localparam int CntW = $clog2(MAX_ENTRIES + 1);

   state_type      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic           dropped_ff, dropped_in;
   logic [31:0]    mem_win_ff, mem_win_in;
   logic [31:0]    io_win_ff, io_win_in;
   logic [31:0]    mem_cursor_ff, mem_cursor_in;
   logic [31:0]    io_cursor_ff, io_cursor_in;
   logic           rsp_valid_ff, rsp_valid_in;
   entry_type      rsp_entry_ff, rsp_entry_in;
   logic [31:0]    rsp_assigned_ff, rsp_assigned_in;
   logic           rsp_overflow_ff, rsp_overflow_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           accept, item_ok, full, ins_en, pop, head_io;
   logic [31:0]    masked;
   entry_type      new_entry;
   cell_ctl_type   ctl;

   entry_type      cell_entry [MAX_ENTRIES];
   logic           cell_valid [MAX_ENTRIES];
   logic           cell_cond  [MAX_ENTRIES];

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         ST_COLLECT: req_ready = 1'b1;
         ST_EMIT:    pop = !rsp_valid_ff || rsp_ready;
         default:    req_ready = 1'b0;
      endcase
   end

   assign accept  = req_valid && req_ready;
   assign item_ok = (req_probe_readback != 32'd0) && (req_probe_readback != req_original_value);
   assign full    = (count_ff == CntW'(MAX_ENTRIES));
   assign ins_en  = accept && item_ok && !full;
   assign masked  = req_probe_readback &
                    ~(req_original_value[0] ? IO_TYPE_MASK : MEM_TYPE_MASK);

   always_comb begin
      new_entry.tag   = req_entry_tag;
      new_entry.value = req_original_value;
      new_entry.size  = 32'd0 - masked;
      ctl.insert      = ins_en;
      ctl.pop         = pop;
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type l_entry, r_entry;
      logic      l_cond, l_valid, r_valid;
      if (i == 0) begin : g_first
         assign l_entry = new_entry;
         assign l_valid = 1'b0;
         assign l_cond  = 1'b0;
      end else begin : g_mid
         assign l_entry = cell_entry[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_cond  = cell_cond[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign r_entry = new_entry;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_entry = cell_entry[i+1];
         assign r_valid = cell_valid[i+1];
      end
      bssa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_cond   (l_cond),
         .left_entry  (l_entry),
         .left_valid  (l_valid),
         .right_entry (r_entry),
         .right_valid (r_valid),
         .cond        (cell_cond[i]),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ins_en) begin
         count_in = count_ff + CntW'(1);
      end else if (pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && req_final_item && (count_in != '0)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (pop && (count_ff == CntW'(1))) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      dropped_in = dropped_ff;
      if (accept && item_ok && full) begin
         dropped_in = 1'b1;
      end
      if ((pop && (count_ff == CntW'(1))) ||
          (accept && req_final_item && (count_in == '0))) begin
         dropped_in = 1'b0;
      end
   end

   always_comb begin
      mem_win_in = mem_win_ff;
      io_win_in  = io_win_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MEM_WINDOW_BASE: mem_win_in = csr_wdata;
            CSR_IO_WINDOW_BASE:  io_win_in  = csr_wdata;
            default:             mem_win_in = mem_win_ff;
         endcase
      end
   end

   assign head_io = cell_entry[0].value[0];

   always_comb begin
      mem_cursor_in   = mem_cursor_ff;
      io_cursor_in    = io_cursor_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_entry_in    = rsp_entry_ff;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_last_in     = rsp_last_ff;
      if (accept && req_final_item) begin
         mem_cursor_in = mem_win_ff;
         io_cursor_in  = io_win_ff;
      end
      if (pop) begin
         rsp_valid_in    = 1'b1;
         rsp_entry_in    = cell_entry[0];
         rsp_overflow_in = dropped_ff;
         rsp_last_in     = (count_ff == CntW'(1));
         if (head_io) begin
            rsp_assigned_in = cell_entry[0].value | io_cursor_ff;
            io_cursor_in    = io_cursor_ff + cell_entry[0].size;
         end else begin
            rsp_assigned_in = cell_entry[0].value | mem_cursor_ff;
            mem_cursor_in   = mem_cursor_ff + cell_entry[0].size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         mem_win_ff    <= 32'd0;
         io_win_ff     <= 32'd0;
         mem_cursor_ff <= 32'd0;
         io_cursor_ff  <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         mem_win_ff    <= mem_win_in;
         io_win_ff     <= io_win_in;
         mem_cursor_ff <= mem_cursor_in;
         io_cursor_ff  <= io_cursor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_entry_ff    <= rsp_entry_in;
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_tag        = rsp_entry_ff.tag;
   assign rsp_assigned_value    = rsp_assigned_ff;
   assign rsp_region_size       = rsp_entry_ff.size;
   assign rsp_is_io_space       = rsp_entry_ff.value[0];
   assign rsp_capacity_overflow = rsp_overflow_ff;
   assign rsp_last_result       = rsp_last_ff;

endmodule

### sv/bssa_cell.sv
module bssa_cell import bssa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    new_entry,
   input  logic         left_cond,
   input  entry_type    left_entry,
   input  logic         left_valid,
   input  entry_type    right_entry,
   input  logic         right_valid,
   output logic         cond,
   output entry_type    entry,
   output logic         valid
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // The new item belongs here or further up when this cell is empty or smaller.
   assign cond = !valid_ff || (entry_ff.size < new_entry.size);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (ctl.insert) begin
         if (left_cond) begin
            entry_in = left_entry;
            valid_in = left_valid;
         end else if (cond) begin
            entry_in = new_entry;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

### dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bssa_pkg::*;

   localparam int CAPACITY      = MAX_ENTRIES_DEF;
   localparam int ITEM_TARGET   = 210;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int ROWS          = 19;

   typedef struct packed {
      logic [10:0] tag;
      logic [31:0] assigned;
      logic [31:0] span;
      logic        io;
      logic        overflow;
      logic        last;
   } grant_type;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_GRANT,
      ONE_GRANT
   } check_kind_type;

   typedef struct packed {
      logic [10:0]    tag;
      logic [31:0]    orig;
      logic [31:0]    readback;
      logic           fin;
      logic           set_bases;
      logic [31:0]    mem_w;
      logic [31:0]    io_w;
      check_kind_type kind;
      grant_type      typed;
   } stim_row_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        csr_wr_en          = 1'b0;
   logic        csr_index          = CSR_MEM_WINDOW_BASE;
   logic [31:0] csr_wdata          = '0;
   logic        req_valid          = 1'b0;
   logic        req_ready;
   logic [10:0] req_entry_tag      = '0;
   logic [31:0] req_original_value = '0;
   logic [31:0] req_probe_readback = '0;
   logic        req_final_item     = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready          = 1'b0;
   logic [10:0] rsp_result_tag;
   logic [31:0] rsp_assigned_value;
   logic [31:0] rsp_region_size;
   logic        rsp_is_io_space;
   logic        rsp_capacity_overflow;
   logic        rsp_last_result;

   bar_size_sort_allocator dut (.*);

   always #5 clock = ~clock;

   logic [10:0] held_tag   [CAPACITY];
   logic [31:0] held_value [CAPACITY];
   logic [31:0] held_span  [CAPACITY];
   int          held_count   = 0;
   logic        held_dropped = 1'b0;
   logic [31:0] mem_window   = '0;
   logic [31:0] io_window    = '0;

   grant_type    due_grants[$];
   grant_type    new_grants[$];
   stim_row_type directed [ROWS];
   int           error_count = 0;
   int           items_sent  = 0;
   int           cycle_count = 0;
   logic         calm        = 1'b0;

   task automatic allocate(input logic [10:0] tag, input logic [31:0] orig,
                           input logic [31:0] readback, input logic fin);
      int          order[$];
      int          pos;
      logic [31:0] mem_cursor;
      logic [31:0] io_cursor;
      grant_type   g;
      new_grants.delete();
      if (readback != '0 && readback != orig) begin
         if (held_count >= CAPACITY) begin
            held_dropped = 1'b1;
         end else begin
            held_tag[held_count]   = tag;
            held_value[held_count] = orig;
            held_span[held_count]  =
               32'd0 - (readback & ~(orig[0] ? IO_TYPE_MASK : MEM_TYPE_MASK));
            held_count++;
         end
      end
      if (fin) begin
         for (int i = 0; i < held_count; i++) begin
            pos = order.size();
            while (pos > 0 && held_span[order[pos - 1]] < held_span[i]) pos--;
            order.insert(pos, i);
         end
         mem_cursor = mem_window;
         io_cursor  = io_window;
         foreach (order[i]) begin
            g.tag      = held_tag[order[i]];
            g.span     = held_span[order[i]];
            g.io       = held_value[order[i]][0];
            if (g.io) begin
               g.assigned = held_value[order[i]] | io_cursor;
               io_cursor  = io_cursor + g.span;
            end else begin
               g.assigned = held_value[order[i]] | mem_cursor;
               mem_cursor = mem_cursor + g.span;
            end
            g.overflow = held_dropped;
            g.last     = (i == order.size() - 1);
            new_grants.push_back(g);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_csr(input logic idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_MEM_WINDOW_BASE) begin
         mem_window = data;
      end else begin
         io_window = data;
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic [10:0] tag, input logic [31:0] orig,
                            input logic [31:0] readback, input logic fin,
                            input check_kind_type kind, input grant_type typed);
      int gap;
      if (!calm && $urandom_range(0, 99) < 7) begin
         gap = $urandom_range(1, 2);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_entry_tag      <= tag;
      req_original_value <= orig;
      req_probe_readback <= readback;
      req_final_item     <= fin;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      allocate(tag, orig, readback, fin);
      case (kind)
         BY_MODEL: begin
            foreach (new_grants[i]) due_grants.push_back(new_grants[i]);
         end
         ONE_GRANT: begin
            due_grants.push_back(typed);
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [31:0] pick_base();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         default: return $urandom & 32'hFFFF_F000;
      endcase
   endfunction

   always @(posedge clock) begin : watch_results
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_grants.size() == 0) begin
            $display("%0t: unexpected result, expected none, got tag %h value %h",
                     $time, rsp_result_tag, rsp_assigned_value);
            error_count++;
         end else begin
            want = due_grants.pop_front();
            check_field("result_tag", 32'(want.tag), 32'(rsp_result_tag));
            check_field("assigned_value", want.assigned, rsp_assigned_value);
            check_field("region_size", want.span, rsp_region_size);
            check_field("is_io_space", 32'(want.io), 32'(rsp_is_io_space));
            check_field("capacity_overflow", 32'(want.overflow),
                        32'(rsp_capacity_overflow));
            check_field("last_result", 32'(want.last), 32'(rsp_last_result));
         end
      end
      rsp_ready <= (calm || reset) ? 1'b1 : ($urandom_range(0, 99) >= 10);
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int          run_len;
      int          run_no;
      int          pick;
      int          k;
      logic        io;
      logic        long_run;
      logic [10:0] tag;
      logic [31:0] orig;
      logic [31:0] readback;

      directed = '{
         '{11'h000, 32'h0000_0000, 32'hFFFF_F000, 1'b1, 1'b0, 32'h0, 32'h0, ONE_GRANT,
           '{11'h000, 32'h0000_0000, 32'h0000_1000, 1'b0, 1'b0, 1'b1}},
         '{11'h7FF, 32'h0000_0001, 32'hFFFF_FF01, 1'b1, 1'b0, 32'h0, 32'h0, ONE_GRANT,
           '{11'h7FF, 32'h0000_0001, 32'h0000_0100, 1'b1, 1'b0, 1'b1}},
         '{11'h001, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 32'h0, NO_GRANT, '0},
         '{11'h002, 32'hABCD_0000, 32'hABCD_0000, 1'b0, 1'b0, 32'h0, 32'h0, NO_GRANT, '0},
         '{11'h003, 32'hFFFF_FFF0, 32'h0000_000F, 1'b1, 1'b0, 32'h0, 32'h0, ONE_GRANT,
           '{11'h003, 32'hFFFF_FFF0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
         '{11'h004, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0, NO_GRANT, '0},
         '{11'h155, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1, 1'b0, 32'h0, 32'h0, ONE_GRANT,
           '{11'h155, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b1}},
         '{11'h2AA, 32'h0000_0008, 32'hFFFF_0008, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h3FF, 32'h0000_0005, 32'h0000_0005, 1'b1, 1'b0, 32'h0, 32'h0, ONE_GRANT,
           '{11'h2AA, 32'h0000_0008, 32'h0001_0000, 1'b0, 1'b0, 1'b1}},
         '{11'h010, 32'h0000_000C, 32'h0000_0010, 1'b0, 1'b1,
           32'hFFFF_FFFF, 32'hFFFF_FFFF, BY_MODEL, '0},
         '{11'h011, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h012, 32'h0000_0000, 32'hFFFF_FFF0, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h013, 32'h0000_0000, 32'hFFFF_FFF8, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h014, 32'h0000_0003, 32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h015, 32'h0000_0004, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h016, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h7C0, 32'h0000_0001, 32'hFFFF_FF81, 1'b0, 1'b1,
           32'h8000_0000, 32'h0000_1000, BY_MODEL, '0},
         '{11'h038, 32'h0000_0008, 32'hFFF0_0008, 1'b0, 1'b0, 32'h0, 32'h0, BY_MODEL, '0},
         '{11'h007, 32'h0000_0001, 32'hFFFF_FFF1, 1'b1, 1'b0, 32'h0, 32'h0, BY_MODEL, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].set_bases) begin
            settle();
            set_csr(CSR_MEM_WINDOW_BASE, directed[i].mem_w);
            set_csr(CSR_IO_WINDOW_BASE, directed[i].io_w);
         end
         send_item(directed[i].tag, directed[i].orig, directed[i].readback,
                   directed[i].fin, directed[i].kind, directed[i].typed);
      end

      // Long runs overfill the store; the others are short so that settings change often.
      run_no = 0;
      while (items_sent < ITEM_TARGET) begin
         calm = (run_no >= 8 && run_no < 14);
         if (run_no % 3 == 0) begin
            settle();
            set_csr(CSR_MEM_WINDOW_BASE, pick_base());
            set_csr(CSR_IO_WINDOW_BASE, pick_base());
         end
         long_run = (run_no == 4 || run_no == 11);
         run_len  = long_run ? $urandom_range(36, 44) : $urandom_range(1, 8);
         for (int n = 0; n < run_len; n++) begin
            tag     = 11'($urandom);
            orig    = $urandom;
            io      = 1'($urandom_range(0, 1));
            orig[0] = io;
            pick    = long_run ? $urandom_range(26, 99) : $urandom_range(0, 99);
            if (pick < 8) begin
               readback = '0;
            end else if (pick < 14) begin
               readback = orig;
            end else if (pick < 26) begin
               readback = $urandom;
            end else begin
               k = io ? $urandom_range(2, 12) : $urandom_range(4, 20);
               if (pick >= 95) k = $urandom_range(20, 32);
               readback = (32'hFFFF_FFFF << k) | (orig & (io ? IO_TYPE_MASK : MEM_TYPE_MASK));
            end
            send_item(tag, orig, readback, n == run_len - 1, BY_MODEL, '0);
         end
         run_no++;
      end

      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/bssa_pkg.sv
sv/bssa_cell.sv
sv/bar_size_sort_allocator.sv
dv/tb.sv
